### sv/cpe_pkg.sv
package cpe_pkg;

	localparam int DataWidth = 32;
	localparam int FracBits = DataWidth - 3;
	localparam int CordicIterations = 24;
	localparam int HypSteps = CordicIterations + (CordicIterations >= 4 ? 1 : 0)
		+ (CordicIterations >= 13 ? 1 : 0) + (CordicIterations >= 40 ? 1 : 0);
	localparam int CordicWidth = 44;
	localparam int AngleWidth = 64;

	typedef enum logic [2:0] {
		REG_SEMI_A   = 3'd0,
		REG_SEMI_B   = 3'd1,
		REG_KIND     = 3'd2,
		REG_COS_ROT  = 3'd3,
		REG_SIN_ROT  = 3'd4,
		REG_CENTER_X = 3'd5,
		REG_CENTER_Y = 3'd6
	} reg_index_t;

	typedef enum logic [1:0] {
		KIND_ELLIPSE = 2'd0,
		KIND_HYP_X   = 2'd1,
		KIND_HYP_Y   = 2'd2,
		KIND_NONE    = 2'd3
	} conic_kind_t;

	localparam logic signed [63:0] PiQ56 = 64'sh03243F6A8885A309;
	localparam logic signed [63:0] TwoPiQ56 = 64'sh06487ED5110B4612;
	localparam logic signed [63:0] HalfPiQ56 = 64'sh01921FB54442D185;
	localparam logic signed [63:0] Ln2Q56 = 64'sh00B17217F7D1CF7A;
	localparam logic signed [63:0] CircGainQ60 = 64'sd700114967507363239;
	localparam logic signed [63:0] HypGainQ60 = 64'sd1392149336173756981;

	// long division of a constant by a small constant, used at elaboration
	function automatic logic [63:0] quot_const(input logic [63:0] num, input int den);
		logic [63:0] q;
		logic [63:0] rem;
		q = '0;
		rem = '0;
		for (int b = 63; b >= 0; b--) begin
			rem = {rem[62:0], num[b]};
			if (rem >= 64'(den)) begin
				rem = rem - 64'(den);
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	function automatic logic signed [63:0] arc_q56(input int i, input logic hyp);
		logic signed [63:0] sum;
		logic signed [63:0] term;
		sum = '0;
		if (i == 0) begin
			sum = hyp ? 64'sd0 : 64'sh00C90FDAA22168C2;
		end else begin
			for (int k = 1; k <= 56; k += 2) begin
				if (k * i <= 56) begin
					term = $signed(quot_const(64'h1 << (56 - k * i), k));
					if (!hyp && (((k >> 1) & 1) == 1)) sum = sum - term;
					else sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

	function automatic int hyp_shift(input int step);
		int s;
		s = step + 1;
		if (step >= 4) s = step;
		if (step >= 14) s = step - 1;
		if (step >= 42) s = step - 2;
		return s;
	endfunction

	function automatic logic signed [CordicWidth-1:0] gain_init(input logic signed [63:0] g);
		logic signed [63:0] r;
		r = (g + (64'sh1 <<< (60 - FracBits - 1))) >>> (60 - FracBits);
		return r[CordicWidth-1:0];
	endfunction

endpackage

### sv/cpe_if.sv
interface cpe_if #(parameter int PayloadWidth = 33) (input logic clk);
	logic valid;
	logic ready;
	logic [PayloadWidth-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/cpe_cordic.sv
module cpe_cordic (
	input  logic clk,
	input  logic en,
	input  logic hyp_in,
	input  logic signed [63:0] angle_in,
	output logic signed [cpe_pkg::CordicWidth-1:0] x_out,
	output logic signed [cpe_pkg::CordicWidth-1:0] y_out
);
	import cpe_pkg::*;
	localparam int Steps = HypSteps;

	logic signed [CordicWidth-1:0] x_s [Steps+1];
	logic signed [CordicWidth-1:0] y_s [Steps+1];
	logic signed [63:0] z_s [Steps+1];
	logic hyp_s [Steps+1];

	assign x_s[0] = hyp_in ? gain_init(HypGainQ60) : gain_init(CircGainQ60);
	assign y_s[0] = '0;
	assign z_s[0] = angle_in;
	assign hyp_s[0] = hyp_in;

	for (genvar g = 0; g < Steps; g++) begin : g_step
		localparam int CShift = g;
		localparam int HShift = hyp_shift(g);
		localparam logic signed [63:0] CArc = arc_q56(g, 1'b0);
		localparam logic signed [63:0] HArc = arc_q56(hyp_shift(g), 1'b1);
		logic signed [CordicWidth-1:0] x_q, y_q;
		logic signed [63:0] z_q;
		logic h_q;
		logic signed [CordicWidth-1:0] dx, dy;
		logic act;
		always_comb begin
			act = hyp_s[g] || (g < CordicIterations);
			dx = hyp_s[g] ? (y_s[g] >>> HShift) : (y_s[g] >>> CShift);
			dy = hyp_s[g] ? (x_s[g] >>> HShift) : (x_s[g] >>> CShift);
		end
		always_ff @(posedge clk) begin
			if (en) begin
				h_q <= hyp_s[g];
				if (!act) begin
					x_q <= x_s[g];
					y_q <= y_s[g];
					z_q <= z_s[g];
				end else if (z_s[g] >= 0) begin
					x_q <= hyp_s[g] ? x_s[g] + dx : x_s[g] - dx;
					y_q <= y_s[g] + dy;
					z_q <= z_s[g] - (hyp_s[g] ? HArc : CArc);
				end else begin
					x_q <= hyp_s[g] ? x_s[g] - dx : x_s[g] + dx;
					y_q <= y_s[g] - dy;
					z_q <= z_s[g] + (hyp_s[g] ? HArc : CArc);
				end
			end
		end
		assign x_s[g+1] = x_q;
		assign y_s[g+1] = y_q;
		assign z_s[g+1] = z_q;
		assign hyp_s[g+1] = h_q;
	end

	assign x_out = x_s[Steps];
	assign y_out = y_s[Steps];
endmodule

### sv/conic_point_evaluator.sv
// channel | direction | payload
// in_ch   | sink      | {last_in, param}
// out_ch  | source    | {last_out, overflow, point_y, point_x}
// cfg_ch  | sink      | {index[2:0], data[31:0]}
// one item per cycle while out_ch is not stalled; stages: reduce 3, cordic 26, post 4
// the cordic pipeline of 26 stages sets the depth
// reset clears valid bits and sets the config registers to their defaults
// a stall freezes the whole pipeline
module conic_point_evaluator (
	input logic clk,
	input logic arst_n,
	cpe_if.sink in_ch,
	cpe_if.source out_ch,
	cpe_if.sink cfg_ch
);
	import cpe_pkg::*;
	localparam int Depth = 3 + HypSteps + 4;

	logic [31:0] semi_a_q, semi_b_q, cos_q, sin_q, cx_q, cy_q;
	logic [1:0] kind_q;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_dat;
	assign cfg_idx = cfg_ch.payload[34:32];
	assign cfg_dat = cfg_ch.payload[31:0];
	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			semi_a_q <= 32'd65536;
			semi_b_q <= 32'd65536;
			kind_q <= KIND_ELLIPSE;
			cos_q <= 32'h40000000;
			sin_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
		end else if (cfg_ch.valid) begin
			unique case (reg_index_t'(cfg_idx))
				REG_SEMI_A: semi_a_q <= cfg_dat;
				REG_SEMI_B: semi_b_q <= cfg_dat;
				REG_KIND: kind_q <= cfg_dat[1:0];
				REG_COS_ROT: cos_q <= cfg_dat;
				REG_SIN_ROT: sin_q <= cfg_dat;
				REG_CENTER_X: cx_q <= cfg_dat;
				REG_CENTER_Y: cy_q <= cfg_dat;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic [Depth-1:0] vld_q;
	logic en;
	assign en = !vld_q[Depth-1] || out_ch.ready;
	assign in_ch.ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], in_ch.valid};
	end
	logic [Depth-1:0] last_q;
	always_ff @(posedge clk) if (en) last_q <= {last_q[Depth-2:0], in_ch.payload[32]};
	assign out_ch.valid = vld_q[Depth-1];

	logic signed [63:0] t0, t_s1, h_s1;
	logic signed [7:0] n_s1;
	logic signed [63:0] ln2half;
	assign t0 = 64'(signed'(in_ch.payload[31:0])) <<< 28;
	assign ln2half = Ln2Q56 >>> 1;
	// hyperbolic n: search over 25 candidates (independent compares)
	logic signed [7:0] n_c;
	always_comb begin
		n_c = 8'sd0;
		for (int k = -12; k <= 12; k++) begin
			if (t0 > (64'(k) * Ln2Q56 + ln2half - Ln2Q56) && t0 >= -ln2half + 64'(k) * Ln2Q56
				&& t0 <= ln2half + 64'(k) * Ln2Q56)
				n_c = 8'(k);
			if (t0 < -ln2half + 64'(k) * Ln2Q56 && t0 > -ln2half + 64'(k-1) * Ln2Q56
				&& k <= 0)
				n_c = 8'(k - 1) + 8'sd1 - 8'sd1;
		end
	end
	// stage 1: reduce to (-pi, pi] for circular; count ln2 steps for hyperbolic
	always_ff @(posedge clk) begin
		if (en) begin
			if (t0 > PiQ56) t_s1 <= t0 - TwoPiQ56;
			else if (t0 <= -PiQ56) t_s1 <= t0 + TwoPiQ56;
			else t_s1 <= t0;
			n_s1 <= n_c;
			h_s1 <= t0;
		end
	end
	// stage 2: circular fold and hyperbolic remainder
	logic signed [63:0] t_s2, r_s2;
	logic signed [7:0] n_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			if (t_s1 > PiQ56) t_s2 <= t_s1 - TwoPiQ56;
			else t_s2 <= t_s1;
			r_s2 <= h_s1 - 64'(n_s1) * Ln2Q56;
			n_s2 <= n_s1;
		end
	end
	// stage 3: half-pi fold, select angle
	logic signed [63:0] z_s3;
	logic flip_s3, hyp_s3;
	logic signed [7:0] n_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			hyp_s3 <= (kind_q == KIND_HYP_X) || (kind_q == KIND_HYP_Y);
			n_s3 <= n_s2;
			flip_s3 <= 1'b0;
			if (kind_q == KIND_HYP_X || kind_q == KIND_HYP_Y) z_s3 <= r_s2;
			else if (t_s2 > HalfPiQ56) begin z_s3 <= t_s2 - PiQ56; flip_s3 <= 1'b1; end
			else if (t_s2 < -HalfPiQ56) begin z_s3 <= t_s2 + PiQ56; flip_s3 <= 1'b1; end
			else z_s3 <= t_s2;
		end
	end

	logic signed [CordicWidth-1:0] cx_o, cy_o;
	cpe_cordic u_cordic (
		.clk(clk), .en(en), .hyp_in(hyp_s3),
		.angle_in(z_s3), .x_out(cx_o), .y_out(cy_o)
	);
	logic flip_d [HypSteps];
	logic signed [7:0] n_d [HypSteps];
	always_ff @(posedge clk) begin
		if (en) begin
			flip_d[0] <= flip_s3;
			n_d[0] <= n_s3;
			for (int k = 1; k < HypSteps; k++) begin
				flip_d[k] <= flip_d[k-1];
				n_d[k] <= n_d[k-1];
			end
		end
	end

	// post stage 1: to Q30 and recombine
	function automatic logic signed [63:0] to_q30(input logic signed [63:0] v);
		return v <<< (30 - FracBits);
	endfunction
	logic signed [63:0] ep, em, c30, s30;
	logic signed [7:0] nn;
	logic [5:0] na;
	logic signed [63:0] hc_c, hs_c, u_c, v_c;
	always_comb begin
		nn = n_d[HypSteps-1];
		na = nn[7] ? 6'(-nn) : 6'(nn);
		c30 = to_q30(64'(cx_o));
		s30 = to_q30(64'(cy_o));
		ep = to_q30(64'(cx_o) + 64'(cy_o));
		em = to_q30(64'(cx_o) - 64'(cy_o));
		if (!nn[7]) begin ep = ep <<< na; em = em >>> na; end
		else begin ep = ep >>> na; em = em <<< na; end
		hc_c = (ep + em) >>> 1;
		hs_c = (ep - em) >>> 1;
		if (flip_d[HypSteps-1]) begin c30 = -c30; s30 = -s30; end
		case (kind_q)
			KIND_ELLIPSE: begin u_c = c30; v_c = s30; end
			KIND_HYP_X: begin u_c = hc_c; v_c = hs_c; end
			KIND_HYP_Y: begin u_c = hs_c; v_c = hc_c; end
			default: begin u_c = '0; v_c = '0; end
		endcase
	end
	logic signed [63:0] u_p1, v_p1;
	always_ff @(posedge clk) if (en) begin u_p1 <= u_c; v_p1 <= v_c; end

	// post stage 2: semi-axis products, rounded to nearest with ties away from zero
	function automatic logic signed [63:0] mul_semi(input logic [31:0] s,
		input logic signed [63:0] h);
		logic [63:0] m, p;
		m = h[63] ? 64'(-h) : 64'(h);
		p = 64'(s) * (m >> 30) + ((64'(s) * 64'(m[29:0]) + 64'h20000000) >> 30);
		return h[63] ? -$signed(p) : $signed(p);
	endfunction
	logic signed [63:0] a_p2, b_p2;
	always_ff @(posedge clk) if (en) begin
		a_p2 <= mul_semi(semi_a_q, u_p1);
		b_p2 <= mul_semi(semi_b_q, v_p1);
	end

	// post stage 3: rotation
	function automatic logic signed [63:0] rot_sum(input logic signed [63:0] c1,
		input logic signed [63:0] a, input logic signed [63:0] c2,
		input logic signed [63:0] b);
		logic signed [63:0] hi, lo;
		hi = (c1 >>> 15) * a + (c2 >>> 15) * b;
		lo = (c1 & 64'sh7FFF) * a + (c2 & 64'sh7FFF) * b + (64'sh1 <<< 29);
		return (hi + (lo >>> 15)) >>> 15;
	endfunction
	logic signed [63:0] px_p3, py_p3;
	always_ff @(posedge clk) if (en) begin
		px_p3 <= rot_sum(64'(signed'(cos_q)), a_p2, -64'(signed'(sin_q)), b_p2)
			+ 64'(signed'(cx_q));
		py_p3 <= rot_sum(64'(signed'(sin_q)), a_p2, 64'(signed'(cos_q)), b_p2)
			+ 64'(signed'(cy_q));
	end

	// post stage 4: saturate
	function automatic logic [32:0] sat(input logic signed [63:0] v);
		if (v > 64'sd2147483647) return {1'b1, 32'h7FFFFFFF};
		if (v < -64'sd2147483648) return {1'b1, 32'h80000000};
		return {1'b0, v[31:0]};
	endfunction
	logic [32:0] sx, sy;
	logic [31:0] px_q, py_q;
	logic ov_q;
	assign sx = sat(px_p3);
	assign sy = sat(py_p3);
	always_ff @(posedge clk) if (en) begin
		px_q <= sx[31:0];
		py_q <= sy[31:0];
		ov_q <= sx[32] | sy[32];
	end
	assign out_ch.payload = {last_q[Depth-1], ov_q, py_q, px_q};
endmodule
